[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge.
`define KRHB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that implies another in the next cycle.
`define KRHB_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

[src/krhb_pkg.sv]
`default_nettype none

package krhb_pkg;

	// Table sizing
	localparam int MAX_TARGETS   = 16;
	localparam int HISTORY_DEPTH = 16;
	localparam int RECORD_BITS   = 64;
	localparam int KEY_BITS      = 16;

	// Port field widths
	localparam int FUNC_W    = 3;
	localparam int ID_W      = 16;
	localparam int POS_W     = 4;
	localparam int REC_W     = 64;
	localparam int STAT_W    = 2;
	localparam int LEN_OUT_W = 5;
	localparam int CNT_OUT_W = 5;
	localparam int LIMIT_W   = 5;

	// Derived internal widths
	localparam int SLOT_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int PTR_W  = $clog2(HISTORY_DEPTH);
	localparam int LEN_W  = $clog2(HISTORY_DEPTH + 1);
	localparam int CNT_W  = $clog2(MAX_TARGETS + 1);
	localparam int ADDR_W = $clog2(MAX_TARGETS * HISTORY_DEPTH);
	localparam int MEM_DEPTH = MAX_TARGETS * HISTORY_DEPTH;
	localparam int CMP_W  = (LEN_W > POS_W) ? LEN_W : POS_W;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_PUSH      = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DROP      = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd2;
	localparam logic [FUNC_W-1:0] FN_CLEAR_ALL = 3'd3;
	localparam logic [FUNC_W-1:0] FN_RD_OLDEST = 3'd4;
	localparam logic [FUNC_W-1:0] FN_RD_NEWEST = 3'd5;
	localparam logic [FUNC_W-1:0] FN_RD_INDEX  = 3'd6;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NONE  = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [SLOT_W-1:0]   slot_idx_t;

endpackage

`default_nettype wire

[src/krhb_ram.sv]
`default_nettype none

// Single-port RAM with registered read data; rdata holds through writes and idle cycles.
module krhb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

`default_nettype wire

[src/keyed_rolling_history_buffer_top.sv]
// Keyed rolling history buffer.
// Input channel (item_valid / item_stall) carries one operation: func, target_id,
// position and record_in. Output channel (result_valid / result_stall) returns
// exactly one result per operation, in order.
// The target table (used flags, keys, ring pointers, lengths) sits in flops and
// is matched against target_id in parallel; records sit in a single-port
// synchronous RAM, at most one access per operation.
// The result is registered and valid in the cycle after the operation is accepted.
// Throughput: one operation per cycle while no result is held by result_stall;
// the result register and the RAM read port each serve one operation per cycle,
// and a push is visible to a read issued in the very next cycle.
// When result_stall is high with a result waiting, item_stall rises in the same
// cycle and the pending result, including the RAM read data, holds.
// Reset clears the table, the tracked count and sets history_limit to 3.
// History RAM entries need no clearing: only entries written since the owning
// slot was allocated are ever read.
// cfg_wr_en writes history_limit; write it only while no operation is pending.
`default_nettype none
`include "assert_macros.svh"

module keyed_rolling_history_buffer_top import krhb_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// config
	input  wire logic                 cfg_wr_en,
	input  wire logic [LIMIT_W-1:0]   cfg_wr_data,
	// operation channel
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire logic [FUNC_W-1:0]    func,
	input  wire logic [ID_W-1:0]      target_id,
	input  wire logic [POS_W-1:0]     position,
	input  wire logic [REC_W-1:0]     record_in,
	// result channel
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [REC_W-1:0]          record_out,
	output logic [STAT_W-1:0]         status,
	output logic                      known,
	output logic [LEN_OUT_W-1:0]      history_len,
	output logic                      is_full,
	output logic [CNT_OUT_W-1:0]      tracked_count
);

	// Table state
	logic [MAX_TARGETS-1:0] used_q;
	key_t                   key_q [MAX_TARGETS];
	ptr_t                   old_q [MAX_TARGETS];
	len_t                   len_q [MAX_TARGETS];
	logic [CNT_W-1:0]       count_q;
	logic [LIMIT_W-1:0]     limit_q;

	// Result stage
	logic                   valid_s1;
	logic                   rd_s1;
	logic [STAT_W-1:0]      status_s1;
	logic                   known_s1;
	len_t                   len_s1;
	logic                   full_s1;
	logic [CNT_W-1:0]       count_s1;

	// RAM port
	logic                   ram_en;
	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_addr;
	logic [RECORD_BITS-1:0] ram_rdata;

	logic                   accept;
	key_t                   key_in;
	len_t                   lim;

	// Lookup
	logic [MAX_TARGETS-1:0] hit_vec;
	logic                   hit;
	slot_idx_t              hit_idx;
	logic                   any_free;
	slot_idx_t              free_idx;
	slot_idx_t              sel;
	len_t                   cur_len;
	ptr_t                   cur_old;

	// Next-state and result
	logic [MAX_TARGETS-1:0] used_d;
	logic                   wr_slot;
	ptr_t                   old_d;
	len_t                   len_d;
	logic [CNT_W-1:0]       count_d;
	logic                   op_rd;
	logic                   op_wr;
	logic [STAT_W-1:0]      res_status;
	logic                   res_known;
	len_t                   res_len;
	ptr_t                   push_old;
	len_t                   push_len;
	ptr_t                   ring_base;
	ptr_t                   ring_k;
	logic [PTR_W:0]         ring_sum;
	ptr_t                   ring_off;

	function automatic ptr_t ptr_inc(ptr_t p);
		ptr_inc = (int'(p) == HISTORY_DEPTH - 1) ? '0 : p + ptr_t'(1);
	endfunction

	assign key_in = target_id[KEY_BITS-1:0];
	assign item_stall = valid_s1 && result_stall;
	assign accept = item_valid && !item_stall;

	// Effective limit, clipped to 1..HISTORY_DEPTH
	always_comb begin
		if (limit_q == '0) begin
			lim = len_t'(1);
		end else if (int'(limit_q) > HISTORY_DEPTH) begin
			lim = len_t'(HISTORY_DEPTH);
		end else begin
			lim = len_t'(limit_q);
		end
	end

	// Parallel key match and lowest free slot
	always_comb begin
		hit_idx = '0;
		for (int s = 0; s < MAX_TARGETS; s++) begin
			hit_vec[s] = used_q[s] && (key_q[s] == key_in);
			if (hit_vec[s]) begin
				hit_idx = hit_idx | slot_idx_t'(s);
			end
		end
		hit = |hit_vec;
		any_free = 1'b0;
		free_idx = '0;
		for (int s = MAX_TARGETS - 1; s >= 0; s--) begin
			if (!used_q[s]) begin
				any_free = 1'b1;
				free_idx = slot_idx_t'(s);
			end
		end
	end

	assign sel     = hit ? hit_idx : free_idx;
	assign cur_len = hit ? len_q[hit_idx] : '0;
	assign cur_old = hit ? old_q[hit_idx] : '0;

	// Push drops one oldest record first when at or above the limit
	always_comb begin
		if (cur_len >= lim) begin
			push_old = ptr_inc(cur_old);
			push_len = cur_len - len_t'(1);
		end else begin
			push_old = cur_old;
			push_len = cur_len;
		end
	end

	// Ring offset within the slot's region
	always_comb begin
		ring_base = (func == FN_PUSH) ? push_old : cur_old;
		case (func)
			FN_PUSH:      ring_k = ptr_t'(push_len);
			FN_RD_NEWEST: ring_k = ptr_t'(cur_len - len_t'(1));
			FN_RD_INDEX:  ring_k = ptr_t'(position);
			default:      ring_k = '0;
		endcase
		ring_sum = {1'b0, ring_base} + {1'b0, ring_k};
		if (int'(ring_sum) >= HISTORY_DEPTH) begin
			ring_off = ptr_t'(int'(ring_sum) - HISTORY_DEPTH);
		end else begin
			ring_off = ptr_t'(ring_sum);
		end
	end

	assign ram_addr = ADDR_W'(ADDR_W'(sel) * ADDR_W'(HISTORY_DEPTH) + ADDR_W'(ring_off));
	assign ram_en   = accept && (op_rd || op_wr);
	assign ram_we   = op_wr;

	// Operation decode
	always_comb begin
		used_d     = used_q;
		wr_slot    = 1'b0;
		old_d      = cur_old;
		len_d      = cur_len;
		count_d    = count_q;
		op_rd      = 1'b0;
		op_wr      = 1'b0;
		res_status = ST_OK;
		res_known  = hit;
		res_len    = cur_len;
		case (func)
			FN_PUSH: begin
				if (!hit && !any_free) begin
					res_status = ST_FULL;
				end else begin
					op_wr       = 1'b1;
					wr_slot     = 1'b1;
					used_d[sel] = 1'b1;
					old_d       = push_old;
					len_d       = push_len + len_t'(1);
					if (!hit) begin
						count_d = count_q + CNT_W'(1);
					end
					res_known = 1'b1;
					res_len   = push_len + len_t'(1);
				end
			end
			FN_DROP: begin
				if (!hit || cur_len == '0) begin
					res_status = ST_NONE;
				end else if (cur_len == len_t'(1)) begin
					used_d[hit_idx] = 1'b0;
					count_d   = count_q - CNT_W'(1);
					res_known = 1'b0;
					res_len   = '0;
				end else begin
					wr_slot = 1'b1;
					old_d   = ptr_inc(cur_old);
					len_d   = cur_len - len_t'(1);
					res_len = cur_len - len_t'(1);
				end
			end
			FN_CLEAR: begin
				if (!hit) begin
					res_status = ST_NONE;
				end else begin
					used_d[hit_idx] = 1'b0;
					count_d   = count_q - CNT_W'(1);
					res_known = 1'b0;
					res_len   = '0;
				end
			end
			FN_CLEAR_ALL: begin
				used_d    = '0;
				count_d   = '0;
				res_known = 1'b0;
				res_len   = '0;
			end
			FN_RD_OLDEST, FN_RD_NEWEST: begin
				if (!hit || cur_len == '0) begin
					res_status = ST_NONE;
				end else begin
					op_rd = 1'b1;
				end
			end
			FN_RD_INDEX: begin
				if (!hit || cur_len == '0) begin
					res_status = ST_NONE;
				end else if (CMP_W'(position) >= CMP_W'(cur_len)) begin
					res_status = ST_RANGE;
				end else begin
					op_rd = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			count_q  <= '0;
			limit_q  <= LIMIT_W'(3);
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (accept) begin
				used_q  <= used_d;
				count_q <= count_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (!result_stall) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Slot pointers and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (wr_slot) begin
				key_q[sel] <= key_in;
				old_q[sel] <= old_d;
				len_q[sel] <= len_d;
			end
			rd_s1     <= op_rd;
			status_s1 <= res_status;
			known_s1  <= res_known;
			len_s1    <= res_len;
			full_s1   <= res_known && (res_len >= lim);
			count_s1  <= count_d;
		end
	end

	krhb_ram #(
		.WIDTH(RECORD_BITS),
		.DEPTH(MEM_DEPTH)
	) u_hist_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(record_in[RECORD_BITS-1:0]),
		.rdata(ram_rdata)
	);

	// Result outputs
	assign result_valid  = valid_s1;
	assign record_out    = rd_s1 ? REC_W'(ram_rdata) : '0;
	assign status        = status_s1;
	assign known         = known_s1;
	assign history_len   = LEN_OUT_W'(len_s1);
	assign is_full       = full_s1;
	assign tracked_count = CNT_OUT_W'(count_s1);

	// Checks
	`KRHB_ASSERT(a_count_matches, count_q == CNT_W'($countones(used_q)), "tracked count mismatch")
	`KRHB_ASSERT(a_single_hit, $onehot0(hit_vec), "target id matched in two slots")
	`KRHB_ASSERT_NEXT(a_rdata_held, valid_s1 && result_stall && rd_s1, $stable(ram_rdata), "rdata moved")
	`KRHB_ASSERT_NEXT(a_accept_result, accept, valid_s1, "accepted transaction produced no result")
	`KRHB_ASSERT(a_read_ok, !(valid_s1 && rd_s1) || (status_s1 == ST_OK && known_s1), "read result with bad status")

endmodule

`default_nettype wire

[verif/keyed_rolling_history_buffer_top_tb.sv]
`timescale 1ns / 1ps

module keyed_rolling_history_buffer_top_tb import krhb_pkg::*;;

	// func code left undefined by the block; must leave state untouched
	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
	localparam int DRAIN_LIMIT = 2000;
	localparam int EXP_DEPTH   = 8;
	localparam int POOL_MAX    = 32;

	typedef struct packed {
		logic [REC_W-1:0]     rec;
		logic [STAT_W-1:0]    st;
		logic                 known;
		logic [LEN_OUT_W-1:0] len;
		logic                 full;
		logic [CNT_OUT_W-1:0] cnt;
	} outcome_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [LIMIT_W-1:0]   cfg_wr_data;
	logic                 item_valid;
	logic                 item_stall;
	logic [FUNC_W-1:0]    func;
	logic [ID_W-1:0]      target_id;
	logic [POS_W-1:0]     position;
	logic [REC_W-1:0]     record_in;
	logic                 result_valid;
	logic                 result_stall;
	logic [REC_W-1:0]     record_out;
	logic [STAT_W-1:0]    status;
	logic                 known;
	logic [LEN_OUT_W-1:0] history_len;
	logic                 is_full;
	logic [CNT_OUT_W-1:0] tracked_count;

	keyed_rolling_history_buffer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.func          (func),
		.target_id     (target_id),
		.position      (position),
		.record_in     (record_in),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.record_out    (record_out),
		.status        (status),
		.known         (known),
		.history_len   (history_len),
		.is_full       (is_full),
		.tracked_count (tracked_count)
	);

	// Shadow copy of the target table and history memory
	bit               tbl_used [MAX_TARGETS];
	logic [ID_W-1:0]  tbl_key  [MAX_TARGETS];
	int               tbl_head [MAX_TARGETS];
	int               tbl_len  [MAX_TARGETS];
	logic [REC_W-1:0] rec_mem  [MAX_TARGETS*HISTORY_DEPTH];
	int               tbl_count;
	logic [LIMIT_W-1:0] limit_reg;

	// Expected results in flight, oldest first
	outcome_t exp_buf [EXP_DEPTH];
	int       exp_wr;
	int       exp_rd;
	outcome_t oldest_expected;
	bit       no_idle;
	int       stall_left;
	int       ops_sent;
	int       results_checked;
	int       error_count;
	int       status_seen [4];

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit
	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic void exp_put(input outcome_t o);
		exp_buf[exp_wr % EXP_DEPTH] = o;
		exp_wr++;
	endfunction

	function automatic outcome_t exp_take();
		outcome_t o;
		o = exp_buf[exp_rd % EXP_DEPTH];
		exp_rd++;
		return o;
	endfunction

	function automatic int exp_pending();
		return exp_wr - exp_rd;
	endfunction

	function automatic int find_target(input logic [ID_W-1:0] id);
		for (int s = 0; s < MAX_TARGETS; s++)
			if (tbl_used[s] && tbl_key[s] == id)
				return s;
		return -1;
	endfunction

	function automatic int lowest_free();
		for (int s = 0; s < MAX_TARGETS; s++)
			if (!tbl_used[s])
				return s;
		return -1;
	endfunction

	function automatic int ring_index(input int s, input int k);
		return s * HISTORY_DEPTH + (tbl_head[s] + k) % HISTORY_DEPTH;
	endfunction

	function automatic void release_target(input int s);
		tbl_used[s] = 1'b0;
		tbl_key[s]  = '0;
		tbl_head[s] = 0;
		tbl_len[s]  = 0;
		if (tbl_count > 0)
			tbl_count--;
	endfunction

	// Apply one operation to the shadow table and return the expected result
	function automatic outcome_t predict_history_op(input logic [FUNC_W-1:0] fn,
			input logic [ID_W-1:0] id, input logic [POS_W-1:0] pos,
			input logic [REC_W-1:0] rec);
		outcome_t res;
		int s;
		int lim;
		res = '0;
		res.st = ST_OK;
		lim = (limit_reg == 0) ? 1 : ((limit_reg > HISTORY_DEPTH) ? HISTORY_DEPTH : limit_reg);
		s = find_target(id);
		case (fn)
			FN_PUSH: begin
				if (s < 0) begin
					s = lowest_free();
					if (s >= 0) begin
						tbl_used[s] = 1'b1;
						tbl_key[s]  = id;
						tbl_head[s] = 0;
						tbl_len[s]  = 0;
						tbl_count++;
					end
				end
				if (s < 0) begin
					res.st = ST_FULL;
				end else begin
					// drop one oldest only, even if the limit was lowered further
					if (tbl_len[s] >= lim) begin
						tbl_head[s] = (tbl_head[s] + 1) % HISTORY_DEPTH;
						tbl_len[s]--;
					end
					rec_mem[ring_index(s, tbl_len[s])] = rec;
					tbl_len[s]++;
				end
			end
			FN_DROP: begin
				if (s < 0 || tbl_len[s] == 0) begin
					res.st = ST_NONE;
				end else begin
					tbl_head[s] = (tbl_head[s] + 1) % HISTORY_DEPTH;
					tbl_len[s]--;
					if (tbl_len[s] == 0) begin
						release_target(s);
						s = -1;
					end
				end
			end
			FN_CLEAR: begin
				if (s < 0) begin
					res.st = ST_NONE;
				end else begin
					release_target(s);
					s = -1;
				end
			end
			FN_CLEAR_ALL: begin
				for (int k = 0; k < MAX_TARGETS; k++) begin
					tbl_used[k] = 1'b0;
					tbl_key[k]  = '0;
					tbl_head[k] = 0;
					tbl_len[k]  = 0;
				end
				tbl_count = 0;
				s = -1;
			end
			FN_RD_OLDEST, FN_RD_NEWEST: begin
				if (s < 0 || tbl_len[s] == 0)
					res.st = ST_NONE;
				else
					res.rec = rec_mem[ring_index(s, (fn == FN_RD_OLDEST) ? 0 : tbl_len[s] - 1)];
			end
			FN_RD_INDEX: begin
				if (s < 0 || tbl_len[s] == 0)
					res.st = ST_NONE;
				else if (pos >= tbl_len[s])
					res.st = ST_RANGE;
				else
					res.rec = rec_mem[ring_index(s, pos)];
			end
			default: begin
			end
		endcase
		if (s >= 0) begin
			res.known = 1'b1;
			res.len   = LEN_OUT_W'(tbl_len[s]);
			res.full  = (tbl_len[s] >= lim);
		end
		res.cnt = CNT_OUT_W'(tbl_count);
		return res;
	endfunction

	// Send one operation; returns right after the accepting edge
	task automatic issue_op(input logic [FUNC_W-1:0] fn, input logic [ID_W-1:0] id,
			input logic [POS_W-1:0] pos, input logic [REC_W-1:0] rec);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		func       <= fn;
		target_id  <= id;
		position   <= pos;
		record_in  <= rec;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		exp_put(predict_history_op(fn, id, pos, rec));
		ops_sent++;
	endtask

	task automatic wait_idle();
		item_valid <= 1'b0;
		while (exp_pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Register write, only with nothing in flight
	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		limit_reg = v;
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [REC_W-1:0] rand_rec();
		return {$urandom, $urandom};
	endfunction

	// Accesses to ids that were never pushed, on an empty table
	task automatic test_empty_table();
		issue_op(FN_RD_OLDEST, 16'h0000, 4'd0, '0);
		issue_op(FN_RD_INDEX, 16'h0000, 4'd15, '1);
		issue_op(FN_DROP, 16'hFFFF, 4'd0, '0);
		issue_op(FN_CLEAR, 16'hFFFF, 4'd0, '0);
		issue_op(FN_UNUSED, 16'h1234, 4'd3, rand_rec());
	endtask

	// Push past the reset limit, then read each end and by index
	task automatic test_push_and_read();
		issue_op(FN_PUSH, 16'hFFFF, 4'd15, '1);
		issue_op(FN_PUSH, 16'hFFFF, 4'd0, '0);
		issue_op(FN_PUSH, 16'hFFFF, 4'd0, 64'h5A5A_5A5A_5A5A_5A5A);
		issue_op(FN_PUSH, 16'hFFFF, 4'd0, 64'hA5A5_A5A5_A5A5_A5A5);
		issue_op(FN_RD_OLDEST, 16'hFFFF, 4'd0, '0);
		issue_op(FN_RD_NEWEST, 16'hFFFF, 4'd0, '0);
		issue_op(FN_RD_INDEX, 16'hFFFF, 4'd1, '0);
		issue_op(FN_RD_INDEX, 16'hFFFF, 4'd3, '0);
		issue_op(FN_RD_INDEX, 16'hFFFF, 4'd15, '0);
		issue_op(FN_UNUSED, 16'hFFFF, 4'd0, '0);
	endtask

	// Slot freed by draining its history, and by clearing it
	task automatic test_drop_and_clear();
		issue_op(FN_PUSH, 16'h0000, 4'd0, rand_rec());
		issue_op(FN_DROP, 16'h0000, 4'd0, '0);
		issue_op(FN_RD_NEWEST, 16'h0000, 4'd0, '0);
		issue_op(FN_CLEAR, 16'hFFFF, 4'd0, '0);
	endtask

	// Limit of zero, and a limit lowered below an existing history length
	task automatic test_limit_cases();
		write_limit(5'd0);
		issue_op(FN_PUSH, 16'h0001, 4'd0, rand_rec());
		issue_op(FN_PUSH, 16'h0001, 4'd0, rand_rec());
		issue_op(FN_RD_OLDEST, 16'h0001, 4'd0, '0);
		write_limit(5'd5);
		repeat (5) issue_op(FN_PUSH, 16'h0002, 4'd0, rand_rec());
		write_limit(5'd2);
		issue_op(FN_PUSH, 16'h0002, 4'd0, rand_rec());
		issue_op(FN_RD_INDEX, 16'h0002, 4'd4, '0);
		issue_op(FN_CLEAR_ALL, 16'h0002, 4'd0, '0);
	endtask

	// Random operations over a pool of ids, with some stray ids and codes
	task automatic run_random_phase(input logic [LIMIT_W-1:0] lim, input int n_items,
			input int pool_size, input int push_pct, input bit quiet);
		logic [ID_W-1:0] pool [POOL_MAX];
		logic [FUNC_W-1:0] fn;
		logic [ID_W-1:0] id;
		write_limit(lim);
		no_idle = quiet;
		for (int i = 0; i < pool_size; i++)
			pool[i] = ID_W'($urandom);
		repeat (n_items) begin
			if ($urandom_range(0, 99) < push_pct) begin
				fn = FN_PUSH;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2: fn = FN_RD_INDEX;
					3, 4:    fn = FN_RD_OLDEST;
					5:       fn = FN_RD_NEWEST;
					6, 7:    fn = FN_DROP;
					8:       fn = FN_CLEAR;
					default: fn = ($urandom_range(0, 3) == 0) ? FN_CLEAR_ALL : FN_UNUSED;
				endcase
			end
			if ($urandom_range(0, 9) == 0)
				id = ID_W'($urandom);
			else
				id = pool[$urandom_range(0, pool_size - 1)];
			issue_op(fn, id, POS_W'($urandom_range(0, 15)), rand_rec());
		end
		no_idle = 1'b0;
	endtask

	// Result side: random stall and in-order compare
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (exp_pending() == 0) begin
					$error("result with no transaction outstanding");
					error_count++;
				end else begin
					oldest_expected = exp_take();
					results_checked++;
					status_seen[status]++;
					if (record_out !== oldest_expected.rec) begin
						$error("record_out: expected %h, got %h", oldest_expected.rec, record_out);
						error_count++;
					end
					if (status !== oldest_expected.st) begin
						$error("status: expected %0d, got %0d", oldest_expected.st, status);
						error_count++;
					end
					if (known !== oldest_expected.known) begin
						$error("known: expected %0d, got %0d", oldest_expected.known, known);
						error_count++;
					end
					if (history_len !== oldest_expected.len) begin
						$error("history_len: expected %0d, got %0d", oldest_expected.len,
							history_len);
						error_count++;
					end
					if (is_full !== oldest_expected.full) begin
						$error("is_full: expected %0d, got %0d", oldest_expected.full, is_full);
						error_count++;
					end
					if (tracked_count !== oldest_expected.cnt) begin
						$error("tracked_count: expected %0d, got %0d", oldest_expected.cnt,
							tracked_count);
						error_count++;
					end
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 6);
				if (stall_left > 0)
					result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				if (stall_left == 0)
					result_stall <= 1'b0;
			end
		end
	end

	// Main sequence
	initial begin
		int drain;
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		item_valid   = 1'b0;
		func         = '0;
		target_id    = '0;
		position     = '0;
		record_in    = '0;
		result_stall = 1'b0;
		stall_left   = 0;
		no_idle      = 1'b0;
		ops_sent     = 0;
		results_checked = 0;
		error_count  = 0;
		exp_wr       = 0;
		exp_rd       = 0;
		tbl_count    = 0;
		limit_reg    = 5'd3;
		for (int s = 0; s < MAX_TARGETS; s++) begin
			tbl_used[s] = 1'b0;
			tbl_key[s]  = '0;
			tbl_head[s] = 0;
			tbl_len[s]  = 0;
		end
		for (int a = 0; a < MAX_TARGETS * HISTORY_DEPTH; a++)
			rec_mem[a] = '0;
		for (int k = 0; k < 4; k++)
			status_seen[k] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_push_and_read();
		test_drop_and_clear();
		test_limit_cases();

		run_random_phase(5'd1, 80, 4, 50, 1'b0);
		run_random_phase(5'd16, 80, 5, 55, 1'b0);
		run_random_phase(5'd31, 80, 3, 50, 1'b1);
		run_random_phase(5'd0, 80, 4, 45, 1'b0);
		run_random_phase(5'd7, 80, 24, 75, 1'b0);
		run_random_phase(5'd2, 80, 6, 40, 1'b1);
		run_random_phase(5'd16, 80, 24, 70, 1'b0);
		run_random_phase(5'd3, 80, 8, 50, 1'b0);

		// Drain outstanding results
		item_valid <= 1'b0;
		drain = 0;
		while (exp_pending() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		if (exp_pending() != 0) begin
			$error("%0d results never arrived", exp_pending());
			error_count++;
		end
		repeat (4) @(posedge clk);

		$display("Sent %0d transactions, checked %0d results, %0d mismatches.",
			ops_sent, results_checked, error_count);
		$display("Status seen: ok %0d, none %0d, range %0d, table full %0d.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
+incdir+src
src/krhb_pkg.sv
src/krhb_ram.sv
src/keyed_rolling_history_buffer_top.sv
verif/keyed_rolling_history_buffer_top_tb.sv
